// File: rtl/core/gregorian_date_info_defines.svh
// Assertion macros shared by the calendar block.
`ifndef GREGORIAN_DATE_INFO_DEFINES_SVH
`define GREGORIAN_DATE_INFO_DEFINES_SVH

// Generic clocked check, disabled during reset.
`define GDI_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gregorian_date_info check failed");

// Same-cycle implication check.
`define GDI_ASSERT_IMPLY(label, clk, rst, cond, expr) \
   `GDI_ASSERT(label, clk, rst, (cond) |-> (expr))

`endif

// File: rtl/core/gdi_pkg.sv
// Types, constants and calendar tables for the Gregorian date block.
package gdi_pkg;

   localparam logic [3:0]  MONTH_FEB      = 4'd2;
   localparam logic [3:0]  MONTH_DEC      = 4'd12;
   localparam logic [8:0]  DAYS_YEAR      = 9'd365;
   localparam logic [8:0]  DAYS_LEAP_YEAR = 9'd366;
   localparam logic [2:0]  WEEKDAY_FRI    = 3'd5;
   localparam logic [2:0]  WEEKDAY_SAT    = 3'd6;
   localparam logic [14:0] YEAR_OFFSET    = 15'd400;

   // reciprocal multipliers for constant division
   localparam logic [12:0] DIV25_T_MUL   = 13'd5243;   // t / 25, t < 8192
   localparam int          DIV25_T_SHIFT = 17;
   localparam logic [14:0] DIV25_Y_MUL   = 15'd20972;  // y / 25, y < 16384
   localparam int          DIV25_Y_SHIFT = 19;
   localparam logic [15:0] MOD7_MUL      = 16'd37450;  // s / 7, s < 32768
   localparam int          MOD7_SHIFT    = 18;

   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
   } req_type;

   typedef struct packed {
      logic        date_valid;
      logic        leap_year;
      logic [4:0]  month_length;
      logic [2:0]  weekday;
      logic        is_weekend;
      logic        is_week_last_day;
      logic [2:0]  days_to_week_end;
      logic [4:0]  days_to_month_end;
      logic [8:0]  days_to_year_end;
      logic [13:0] next_year;
      logic [3:0]  next_month;
      logic [4:0]  next_day;
   } rsp_type;

   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [14:0] yy;
      logic [12:0] quarter;
      logic [25:0] prod_century;
      logic [28:0] prod_y25;
   } s1_type;

   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic        leap;
      logic [4:0]  mlen;
      logic        valid;
      logic [8:0]  doy;
      logic [14:0] sum;
   } s2_type;

   typedef struct packed {
      logic        leap;
      logic [4:0]  mlen;
      logic        valid;
      logic [4:0]  to_month_end;
      logic [8:0]  to_year_end;
      logic [13:0] ny;
      logic [3:0]  nm;
      logic [4:0]  nd;
   } s3_type;

   function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                        len = leap ? 5'd29 : 5'd28;
         default:                                     len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [8:0] days_before(input logic [3:0] m);
      logic [8:0] n;
      case (m)
         4'd1:    n = 9'd0;
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

   // (31 * shifted_month) / 12, March counted as month 1
   function automatic logic [4:0] month_offset(input logic [3:0] m);
      logic [4:0] n;
      case (m)
         4'd1:    n = 5'd28;
         4'd2:    n = 5'd31;
         4'd3:    n = 5'd2;
         4'd4:    n = 5'd5;
         4'd5:    n = 5'd7;
         4'd6:    n = 5'd10;
         4'd7:    n = 5'd12;
         4'd8:    n = 5'd15;
         4'd9:    n = 5'd18;
         4'd10:   n = 5'd20;
         4'd11:   n = 5'd23;
         4'd12:   n = 5'd25;
         default: n = 5'd0;
      endcase
      return n;
   endfunction

endpackage

// File: rtl/core/gdi_mod7.sv
// Two-step modulo-7 reduction: registered reciprocal product, then correction.
module gdi_mod7 (
   input  logic        clock,
   input  logic [14:0] sum_in,
   output logic [2:0]  rem
);

   logic [30:0] prod_in;
   logic [30:0] prod_ff;
   logic [14:0] sum_ff;
   logic [12:0] quo;
   logic [14:0] diff;

   assign prod_in = 31'(sum_in) * 31'(gdi_pkg::MOD7_MUL);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
   end

   always_comb begin
      quo  = prod_ff[gdi_pkg::MOD7_SHIFT + 12 : gdi_pkg::MOD7_SHIFT];
      diff = sum_ff - (15'(quo) << 3) + 15'(quo);
      rem  = diff[2:0];
   end

endmodule

// File: rtl/core/gregorian_date_info.sv
// Gregorian date facts: an accepted item passes through the stage registers listed below to rsp_strobe.
// One item per clock; busy is never raised, so start is taken every cycle.
// Stages: reciprocal products, leap/length/day sums, mod-7 product and next date, output.
// Each result is shown for one cycle; the receiver cannot stall.
// Synchronous reset clears all stage valid bits and the strobe.
`include "gregorian_date_info_defines.svh"

module gregorian_date_info (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  gdi_pkg::req_type req_data,
   output logic             rsp_strobe,
   output gdi_pkg::rsp_type rsp_data
);

   gdi_pkg::s1_type  s1_in, s1_ff;
   gdi_pkg::s2_type  s2_in, s2_ff;
   gdi_pkg::s3_type  s3_in, s3_ff;
   gdi_pkg::rsp_type rsp_in, rsp_ff;
   logic             v1_in, v1_ff, v2_ff, v3_ff, strobe_ff;

   logic       early;
   logic [7:0] q100;
   logic [5:0] q400;
   logic [9:0] q25;
   logic [13:0] r25;
   logic [2:0] wd;

   assign busy  = 1'b0;
   assign v1_in = start && !busy;

   // stage 1: year shift and reciprocal products
   always_comb begin
      early              = (req_data.month <= gdi_pkg::MONTH_FEB);
      s1_in.year         = req_data.year;
      s1_in.month        = req_data.month;
      s1_in.day          = req_data.day;
      s1_in.yy           = 15'(req_data.year) + gdi_pkg::YEAR_OFFSET - 15'(early);
      s1_in.quarter      = s1_in.yy[14:2];
      s1_in.prod_century = 26'(s1_in.quarter) * 26'(gdi_pkg::DIV25_T_MUL);
      s1_in.prod_y25     = 29'(req_data.year) * 29'(gdi_pkg::DIV25_Y_MUL);
   end

   // stage 2: leap year, month length, validity, day sums
   always_comb begin
      q100 = s1_ff.prod_century[gdi_pkg::DIV25_T_SHIFT + 7 : gdi_pkg::DIV25_T_SHIFT];
      q400 = q100[7:2];
      q25  = s1_ff.prod_y25[gdi_pkg::DIV25_Y_SHIFT + 9 : gdi_pkg::DIV25_Y_SHIFT];
      r25  = s1_ff.year - ((14'(q25) << 4) + (14'(q25) << 3) + 14'(q25));
      s2_in.year  = s1_ff.year;
      s2_in.month = s1_ff.month;
      s2_in.day   = s1_ff.day;
      s2_in.leap  = (s1_ff.year[1:0] == 2'd0) &&
                    ((r25 != 14'd0) || (s1_ff.year[3:0] == 4'd0));
      s2_in.mlen  = gdi_pkg::month_length(s1_ff.month, s2_in.leap);
      s2_in.valid = (s2_in.mlen != 5'd0) && (s1_ff.day != 5'd0) &&
                    (s1_ff.day <= s2_in.mlen);
      s2_in.doy   = gdi_pkg::days_before(s1_ff.month) + 9'(s1_ff.day) +
                    9'(s2_in.leap && (s1_ff.month > gdi_pkg::MONTH_FEB));
      s2_in.sum   = 15'(s1_ff.day) + s1_ff.yy + 15'(s1_ff.quarter) - 15'(q100) +
                    15'(q400) + 15'(gdi_pkg::month_offset(s1_ff.month));
   end

   gdi_mod7 u_mod7 (
      .clock  (clock),
      .sum_in (s2_ff.sum),
      .rem    (wd)
   );

   // stage 3: following date and remaining-day counts
   always_comb begin
      s3_in.leap         = s2_ff.leap;
      s3_in.mlen         = s2_ff.mlen;
      s3_in.valid        = s2_ff.valid;
      s3_in.to_month_end = 5'd0;
      s3_in.to_year_end  = 9'd0;
      s3_in.ny           = 14'd0;
      s3_in.nm           = 4'd0;
      s3_in.nd           = 5'd0;
      if (s2_ff.valid) begin
         s3_in.to_month_end = s2_ff.mlen - s2_ff.day + 5'd1;
         s3_in.to_year_end  = (s2_ff.leap ? gdi_pkg::DAYS_LEAP_YEAR : gdi_pkg::DAYS_YEAR) -
                              s2_ff.doy + 9'd1;
         s3_in.ny = s2_ff.year;
         s3_in.nm = s2_ff.month;
         s3_in.nd = s2_ff.day + 5'd1;
         if (s2_ff.day == s2_ff.mlen) begin
            s3_in.nd = 5'd1;
            if (s2_ff.month == gdi_pkg::MONTH_DEC) begin
               s3_in.nm = 4'd1;
               s3_in.ny = s2_ff.year + 14'd1;
            end else begin
               s3_in.nm = s2_ff.month + 4'd1;
            end
         end
      end
   end

   // stage 4: weekday facts and result register
   always_comb begin
      rsp_in                   = '0;
      rsp_in.date_valid        = s3_ff.valid;
      rsp_in.leap_year         = s3_ff.leap;
      rsp_in.month_length      = s3_ff.mlen;
      rsp_in.days_to_month_end = s3_ff.to_month_end;
      rsp_in.days_to_year_end  = s3_ff.to_year_end;
      rsp_in.next_year         = s3_ff.ny;
      rsp_in.next_month        = s3_ff.nm;
      rsp_in.next_day          = s3_ff.nd;
      if (s3_ff.valid) begin
         rsp_in.weekday          = wd;
         rsp_in.is_weekend       = (wd == gdi_pkg::WEEKDAY_FRI) || (wd == gdi_pkg::WEEKDAY_SAT);
         rsp_in.is_week_last_day = (wd == gdi_pkg::WEEKDAY_SAT);
         rsp_in.days_to_week_end = gdi_pkg::WEEKDAY_SAT - wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         v1_ff     <= v1_in;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         strobe_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      s2_ff  <= s2_in;
      s3_ff  <= s3_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   `GDI_ASSERT(a_latency, clock, reset, (start && !busy) |-> ##4 rsp_strobe)
   `GDI_ASSERT_IMPLY(a_invalid_zero, clock, reset, rsp_strobe && !rsp_data.date_valid,
      rsp_data.weekday == 3'd0 && rsp_data.days_to_year_end == 9'd0 && rsp_data.next_day == 5'd0)
   `GDI_ASSERT_IMPLY(a_valid_range, clock, reset, rsp_strobe && rsp_data.date_valid,
      rsp_data.weekday != 3'd7 && rsp_data.days_to_month_end != 5'd0 && rsp_data.next_day != 5'd0)

endmodule

// File: sim/tb_gregorian_date_info.sv
// Self-checking testbench for the Gregorian date information block.
`timescale 1ns / 100ps

module tb_gregorian_date_info;

   localparam int   CYCLE_LIMIT   = 200000;
   localparam int   RANDOM_DATES  = 500;
   localparam int   QUIET_TAIL    = 60;
   localparam int   SETTLE_CYCLES = 8;
   localparam logic [3:0] MONTH_JAN = 4'd1;

   typedef struct {
      gdi_pkg::req_type date;
      bit               drain_first;
   } pending_date_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   gdi_pkg::req_type req_data = '0;
   logic             rsp_strobe;
   gdi_pkg::rsp_type rsp_data;

   pending_date_type pending_q[$];
   gdi_pkg::rsp_type expected_facts_q[$];

   bit item_taken = 1'b0;
   bit was_taken;
   int idle_left = 0;
   int idle_pct = 10;
   int cycle_count = 0;
   int mismatches = 0;
   int results_seen = 0;
   int dates_sent = 0;
   int valid_dates = 0;
   int leap_dates = 0;
   int month_rollovers = 0;
   int year_rollovers = 0;

   gregorian_date_info u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit is_leap_year(input int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int days_in_month(input int m, input bit leap);
      if (m < 1 || m > 12)
         return 0;
      if (m == gdi_pkg::MONTH_FEB)
         return leap ? 29 : 28;
      if (m == 4 || m == 6 || m == 9 || m == 11)
         return 30;
      return 31;
   endfunction

   // weekday from an absolute day count; the 400-year shift keeps year 0 positive
   function automatic gdi_pkg::rsp_type predict_date_facts(input gdi_pkg::req_type item);
      gdi_pkg::rsp_type r;
      int y, m, d, mlen, doy, ylen, shifted, day_count, wd;
      bit leap;
      y = int'(item.year);
      m = int'(item.month);
      d = int'(item.day);
      r = '0;
      leap = is_leap_year(y);
      mlen = days_in_month(m, leap);
      r.leap_year = leap;
      r.month_length = 5'(mlen);
      if (mlen == 0 || d < 1 || d > mlen)
         return r;
      doy = d;
      for (int i = 1; i < m; i++)
         doy += days_in_month(i, leap);
      ylen = leap ? 366 : 365;
      shifted = y + 399;
      day_count = shifted * 365 + shifted / 4 - shifted / 100 + shifted / 400 + doy;
      wd = day_count % 7;
      r.date_valid = 1'b1;
      r.weekday = 3'(wd);
      r.is_weekend = (wd == gdi_pkg::WEEKDAY_FRI) || (wd == gdi_pkg::WEEKDAY_SAT);
      r.is_week_last_day = (wd == gdi_pkg::WEEKDAY_SAT);
      r.days_to_week_end = 3'(gdi_pkg::WEEKDAY_SAT - wd);
      r.days_to_month_end = 5'(mlen - d + 1);
      r.days_to_year_end = 9'(ylen - doy + 1);
      r.next_year = 14'(y);
      r.next_month = 4'(m);
      r.next_day = 5'(d + 1);
      if (d == mlen) begin
         r.next_day = 5'd1;
         if (m == gdi_pkg::MONTH_DEC) begin
            r.next_month = MONTH_JAN;
            r.next_year = 14'(y + 1);
         end else begin
            r.next_month = 4'(m + 1);
         end
      end
      return r;
   endfunction

   function automatic gdi_pkg::req_type random_date();
      gdi_pkg::req_type r;
      int pick, len;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         r.year = 14'($urandom);
         r.month = 4'($urandom);
         r.day = 5'($urandom);
         return r;
      end
      if (pick < 75)
         r.year = 14'($urandom_range(1, 9999));
      else if (pick < 90)
         r.year = 14'($urandom_range(0, 16383));
      else begin
         case ($urandom_range(0, 7))
            0: r.year = 14'd0;
            1: r.year = 14'd1;
            2: r.year = 14'd100;
            3: r.year = 14'd400;
            4: r.year = 14'd1900;
            5: r.year = 14'd2000;
            6: r.year = 14'd9999;
            default: r.year = 14'd16383;
         endcase
      end
      r.month = 4'($urandom_range(1, 12));
      len = days_in_month(int'(r.month), is_leap_year(int'(r.year)));
      r.day = ($urandom_range(0, 3) == 0) ? 5'(len) : 5'($urandom_range(1, len));
      return r;
   endfunction

   task automatic queue_date(input int y, input int m, input int d, input bit drain);
      pending_date_type p;
      p.date.year = 14'(y);
      p.date.month = 4'(m);
      p.date.day = 5'(d);
      p.drain_first = drain;
      pending_q.push_back(p);
   endtask

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                   results_seen, name, got, want));
   endtask

   task automatic check_date_facts(input gdi_pkg::rsp_type got,
                                   input gdi_pkg::rsp_type want);
      check_field("date_valid", 16'(got.date_valid), 16'(want.date_valid));
      check_field("leap_year", 16'(got.leap_year), 16'(want.leap_year));
      check_field("month_length", 16'(got.month_length), 16'(want.month_length));
      check_field("weekday", 16'(got.weekday), 16'(want.weekday));
      check_field("is_weekend", 16'(got.is_weekend), 16'(want.is_weekend));
      check_field("is_week_last_day", 16'(got.is_week_last_day),
                  16'(want.is_week_last_day));
      check_field("days_to_week_end", 16'(got.days_to_week_end),
                  16'(want.days_to_week_end));
      check_field("days_to_month_end", 16'(got.days_to_month_end),
                  16'(want.days_to_month_end));
      check_field("days_to_year_end", 16'(got.days_to_year_end),
                  16'(want.days_to_year_end));
      check_field("next_year", 16'(got.next_year), 16'(want.next_year));
      check_field("next_month", 16'(got.next_month), 16'(want.next_month));
      check_field("next_day", 16'(got.next_day), 16'(want.next_day));
   endtask

   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         was_taken = item_taken;
         if (item_taken) begin
            void'(pending_q.pop_front());
            item_taken = 1'b0;
            if ($urandom_range(0, 63) == 0)
               idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
         end
         if (start && !was_taken) begin
            // item still waiting for acceptance: hold it
         end else if (idle_left > 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (pending_q.size() == 0) begin
            start <= 1'b0;
         end else if (pending_q[0].drain_first && expected_facts_q.size() != 0) begin
            start <= 1'b0;
         end else if (pending_q.size() > QUIET_TAIL && idle_pct > 0 &&
                      $urandom_range(0, 99) < idle_pct) begin
            idle_left = $urandom_range(1, 15) - 1;
            start <= 1'b0;
         end else begin
            start <= 1'b1;
            req_data <= pending_q[0].date;
         end
      end
   end

   always @(posedge clock) begin
      gdi_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            results_seen++;
            if (expected_facts_q.size() == 0) begin
               report_mismatch($sformatf("result %0d with no item pending", results_seen));
            end else begin
               want = expected_facts_q.pop_front();
               check_date_facts(rsp_data, want);
            end
         end
         if (start && busy === 1'b0) begin
            want = predict_date_facts(req_data);
            expected_facts_q.push_back(want);
            item_taken = 1'b1;
            dates_sent++;
            valid_dates += int'(want.date_valid);
            leap_dates += int'(want.leap_year);
            if (want.date_valid && want.next_day == 5'd1)
               month_rollovers++;
            if (want.date_valid && want.next_month == MONTH_JAN && want.next_day == 5'd1)
               year_rollovers++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_facts_q.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      queue_date(0, 1, 1, 1'b0);
      queue_date(1, 1, 1, 1'b0);
      queue_date(16383, 12, 31, 1'b0);
      queue_date(9999, 12, 31, 1'b0);
      queue_date(2000, 2, 29, 1'b0);
      queue_date(1900, 2, 29, 1'b0);
      queue_date(1900, 2, 28, 1'b0);
      queue_date(100, 2, 28, 1'b0);
      queue_date(400, 2, 29, 1'b0);
      queue_date(2024, 2, 29, 1'b0);
      queue_date(2023, 2, 29, 1'b0);
      queue_date(2023, 0, 10, 1'b0);
      queue_date(2023, 13, 10, 1'b0);
      queue_date(16383, 15, 31, 1'b0);
      queue_date(2023, 5, 0, 1'b0);
      queue_date(2023, 4, 31, 1'b0);
      queue_date(2023, 1, 31, 1'b0);
      queue_date(2023, 11, 30, 1'b0);
      queue_date(2023, 12, 1, 1'b0);
      queue_date(2024, 5, 31, 1'b0);
      queue_date(2024, 6, 1, 1'b0);
      queue_date(2024, 6, 2, 1'b0);
      queue_date(0, 12, 31, 1'b0);
      for (int i = 0; i < RANDOM_DATES; i++) begin
         pending_date_type p;
         p.date = random_date();
         p.drain_first = (i == 0) || (i % 125 == 0);
         pending_q.push_back(p);
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      while (pending_q.size() != 0)
         @(posedge clock);
      while (expected_facts_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d dates: %0d valid, %0d invalid, %0d in leap years",
               dates_sent, valid_dates, dates_sent - valid_dates, leap_dates);
      $display("Month rollovers %0d, year rollovers %0d, mismatches %0d",
               month_rollovers, year_rollovers, mismatches);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
